[rtl/sapq_pkg.sv]
`default_nettype none

package sapq_pkg;

  // Number of slots in the row of cells.
  localparam int DEPTH = 64;

  // Width of the occupancy count, wide enough to hold DEPTH itself.
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Width of the reported count field.
  localparam int COUNT_OUT_W = 7;

  // Width of the data and priority fields.
  localparam int DATA_W = 32;

  // Operation codes carried on the mode field.
  typedef enum logic {
    MODE_ENQUEUE = 1'b0,
    MODE_DEQUEUE = 1'b1
  } mode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // One stored pair.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t item;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/sapq_cell.sv]
`default_nettype none

module sapq_cell
  import sapq_pkg::*;
(
  input  wire logic   clk,
  input  wire cmd_t   cmd,
  input  wire logic   occupied,
  input  wire entry_t upper,
  input  wire logic   upper_ge,
  input  wire entry_t lower,
  output entry_t      entry,
  output logic        ge
);

  entry_t entry_next;

  // The cell keeps its pair on insert when it is stored and ranks at or above the new one.
  assign ge = occupied && ($signed(entry.prio) >= $signed(cmd.item.prio));

  // On insert the cell either keeps, takes the new pair or takes its upper neighbour's;
  // on removal every cell takes its lower neighbour's pair (the last cell keeps its own).
  always_comb begin
    entry_next = entry;
    if (cmd.enq) begin
      if (!ge) begin
        entry_next = upper_ge ? cmd.item : upper;
      end
    end else if (cmd.deq) begin
      entry_next = lower;
    end
  end

  // Pair register; its contents only matter while the slot is occupied.
  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

[rtl/sorted_array_priority_queue.sv]
// Sorted-array max priority queue built as a row of DEPTH cells.
// Input channel (in_valid/in_stall) carries mode, item_value and item_priority;
// mode selects an enqueue of the pair or a dequeue of the highest priority.
// A transfer happens at a rising edge where valid is high and stall is low.
// Output channel (out_valid/out_stall) carries exactly one result per input
// transfer: status, the removed pair, the count and the top pair afterwards,
// and the empty and full flags.
// Every cell compares its stored priority with the incoming one and shifts
// with its neighbours in the same cycle, so the whole row is updated at once.
// The result is registered and valid in the cycle after the input transfer;
// one item is taken in every cycle while the receiver does not stall.
// A single output register holds the result; when the receiver stalls with a
// result waiting, in_stall is raised until that result is transferred.
// Reset empties the queue at once (count cleared) and drops any pending
// result; slot contents are not cleared, as only occupied slots are read.
`default_nettype none

module sorted_array_priority_queue
  import sapq_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      mode,
  input  wire logic signed [DATA_W-1:0]  item_value,
  input  wire logic signed [DATA_W-1:0]  item_priority,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [1:0]                     status,
  output logic signed [DATA_W-1:0]       removed_value,
  output logic signed [DATA_W-1:0]       removed_priority,
  output logic [COUNT_OUT_W-1:0]         count_after,
  output logic signed [DATA_W-1:0]       top_value,
  output logic signed [DATA_W-1:0]       top_priority,
  output logic                           is_empty,
  output logic                           is_full
);

  logic             accept;
  logic             is_enq;
  logic             enq_ok;
  logic             deq_ok;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  cmd_t             cmd;
  entry_t           item;
  entry_t           top_next;
  entry_t           removed_next;
  status_t          status_next;
  entry_t           cells [DEPTH];
  logic             ge [DEPTH];

  // Input transfer and the operation it requests.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_enq   = (mode_t'(mode) == MODE_ENQUEUE);
  assign enq_ok   = accept && is_enq && (count != CNT_W'(DEPTH));
  assign deq_ok   = accept && !is_enq && (count != '0);

  assign item.value = item_value;
  assign item.prio  = item_priority;

  assign cmd.enq  = enq_ok;
  assign cmd.deq  = deq_ok;
  assign cmd.item = item;

  // Row of cells, highest priority in cell 0.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t upper;
    logic   upper_ge;
    entry_t lower;

    if (i == 0) begin : g_head
      assign upper    = item;
      assign upper_ge = 1'b1;
    end else begin : g_body
      assign upper    = cells[i-1];
      assign upper_ge = ge[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign lower = cells[i];
    end else begin : g_inner
      assign lower = cells[i+1];
    end

    sapq_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .occupied (count > CNT_W'(i)),
      .upper    (upper),
      .upper_ge (upper_ge),
      .lower    (lower),
      .entry    (cells[i]),
      .ge       (ge[i])
    );
  end

  // Next count, top pair and status of the result.
  always_comb begin
    count_next   = count;
    top_next     = cells[0];
    removed_next = '0;
    status_next  = STATUS_DONE;
    if (enq_ok) begin
      count_next = count + CNT_W'(1);
      top_next   = ge[0] ? cells[0] : item;
    end else if (deq_ok) begin
      count_next   = count - CNT_W'(1);
      top_next     = cells[1];
      removed_next = cells[0];
    end else if (is_enq) begin
      status_next = STATUS_FULL;
    end else begin
      status_next = STATUS_EMPTY;
    end
    if (count_next == '0) begin
      top_next = '0;
    end
  end

  // Occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result register, loaded on each input transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      status           <= status_next;
      removed_value    <= removed_next.value;
      removed_priority <= removed_next.prio;
      count_after      <= COUNT_OUT_W'(count_next);
      top_value        <= top_next.value;
      top_priority     <= top_next.prio;
      is_empty         <= (count_next == '0);
      is_full          <= (count_next == CNT_W'(DEPTH));
    end
  end

`ifndef SYNTH
  // The count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("occupancy count above DEPTH");

  // The count moves only on an input transfer.
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count))
    else $error("count changed without a transfer");

  // The two highest slots stay in descending priority order.
  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> ($signed(cells[0].prio) >= $signed(cells[1].prio)))
    else $error("top slots out of order");

  // A rejected enqueue is reported only with the full flag set.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STATUS_FULL)) |-> is_full)
    else $error("full status without full flag");
`endif

endmodule

`default_nettype wire

[tb/sv/sorted_array_priority_queue_tb.sv]
`default_nettype none

module sorted_array_priority_queue_tb;
  import sapq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_TARGET   = 1050;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     mode = MODE_ENQUEUE;
  logic signed [DATA_W-1:0] item_value = '0;
  logic signed [DATA_W-1:0] item_priority = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] removed_value;
  logic signed [DATA_W-1:0] removed_priority;
  logic [COUNT_OUT_W-1:0]   count_after;
  logic signed [DATA_W-1:0] top_value;
  logic signed [DATA_W-1:0] top_priority;
  logic                     is_empty;
  logic                     is_full;

  // When set, neither side inserts idle cycles.
  bit steady = 1'b0;
  int items_sent = 0;

  // One expected result of the queue.
  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] removed_value;
    logic signed [DATA_W-1:0] removed_priority;
    logic [COUNT_OUT_W-1:0]   count;
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] top_priority;
    logic                     empty;
    logic                     full;
  } pq_outcome_t;

  // Shadow copy of the ordered slots and the queue of results still owed.
  class pq_scoreboard;
    logic signed [DATA_W-1:0] slot_value[DEPTH];
    logic signed [DATA_W-1:0] slot_prio[DEPTH];
    int                       occupancy = 0;
    pq_outcome_t              owed[$];
    int                       errors = 0;

    function int pending();
      return owed.size();
    endfunction

    // Apply one accepted command to the shadow queue and record its result.
    function void note_command(mode_t op, logic signed [DATA_W-1:0] value,
                               logic signed [DATA_W-1:0] prio);
      pq_outcome_t o;
      int pos;
      o.status = STATUS_DONE;
      o.removed_value = '0;
      o.removed_priority = '0;
      o.top_value = '0;
      o.top_priority = '0;
      if (op == MODE_ENQUEUE) begin
        if (occupancy >= DEPTH) begin
          o.status = STATUS_FULL;
        end else begin
          // Entries of equal or higher priority move up, so ties keep arrival order.
          pos = occupancy;
          while (pos > 0 && slot_prio[pos-1] >= prio) begin
            slot_value[pos] = slot_value[pos-1];
            slot_prio[pos] = slot_prio[pos-1];
            pos--;
          end
          slot_value[pos] = value;
          slot_prio[pos] = prio;
          occupancy++;
        end
      end else begin
        if (occupancy == 0) begin
          o.status = STATUS_EMPTY;
        end else begin
          occupancy--;
          o.removed_value = slot_value[occupancy];
          o.removed_priority = slot_prio[occupancy];
        end
      end
      if (occupancy > 0) begin
        o.top_value = slot_value[occupancy-1];
        o.top_priority = slot_prio[occupancy-1];
      end
      o.count = COUNT_OUT_W'(occupancy);
      o.empty = (occupancy == 0);
      o.full = (occupancy >= DEPTH);
      owed.push_back(o);
    endfunction

    function void compare_field(string field, logic [DATA_W-1:0] want,
                                logic [DATA_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %h, actual %h", field, want, got);
        errors++;
      end
    endfunction

    // Compare one transferred result against the oldest expectation.
    function void check_result(logic [1:0] st, logic signed [DATA_W-1:0] rv,
                               logic signed [DATA_W-1:0] rp,
                               logic [COUNT_OUT_W-1:0] cnt,
                               logic signed [DATA_W-1:0] tv,
                               logic signed [DATA_W-1:0] tp, logic emp, logic ful);
      pq_outcome_t o;
      if (owed.size() == 0) begin
        $error("result transfer with no command outstanding");
        errors++;
        return;
      end
      o = owed.pop_front();
      compare_field("status", DATA_W'(o.status), DATA_W'(st));
      compare_field("removed_value", o.removed_value, rv);
      compare_field("removed_priority", o.removed_priority, rp);
      compare_field("count_after", DATA_W'(o.count), DATA_W'(cnt));
      compare_field("top_value", o.top_value, tv);
      compare_field("top_priority", o.top_priority, tp);
      compare_field("is_empty", DATA_W'(o.empty), DATA_W'(emp));
      compare_field("is_full", DATA_W'(o.full), DATA_W'(ful));
    endfunction
  endclass

  pq_scoreboard book = new();

  sorted_array_priority_queue u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length: mostly none or short, occasionally long.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Priorities lean towards a narrow band so that ties are frequent.
  function automatic logic signed [DATA_W-1:0] pick_priority();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $signed($urandom_range(0, 6)) - 3;
    if (r < 8) return $urandom;
    if (r == 8) return $urandom_range(0, 1) ? INT_MAX : INT_MIN;
    return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? INT_MAX : INT_MIN;
    return $urandom;
  endfunction

  // Present one command and hold it until the transfer takes place.
  task automatic send_command(input mode_t op, input logic signed [DATA_W-1:0] value,
                              input logic signed [DATA_W-1:0] prio);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= op;
    item_value <= value;
    item_priority <= prio;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_command(op, value, prio);
    items_sent++;
  endtask

  // Stop sending until every owed result has been transferred.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (book.pending() != 0);
  endtask

  task automatic run_phase(input int length, input int enq_percent);
    mode_t op;
    for (int k = 0; k < length; k++) begin
      op = ($urandom_range(1, 100) <= enq_percent) ? MODE_ENQUEUE : MODE_DEQUEUE;
      send_command(op, pick_value(), pick_priority());
    end
  endtask

  // Receiver: random stalls, held for a random number of cycles.
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      book.check_result(status, removed_value, removed_priority, count_after,
                        top_value, top_priority, is_empty, is_full);
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_left <= pick_gap();
      out_stall <= 1'b0;
    end
  end

  // Ends the run if neither channel makes progress for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int phase_len;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty dequeue, ties, new lowest priority and the extremes.
    send_command(MODE_DEQUEUE, INT_MAX, INT_MAX);
    send_command(MODE_ENQUEUE, 32'sd1, 32'sd0);
    send_command(MODE_ENQUEUE, 32'sd2, 32'sd0);
    send_command(MODE_ENQUEUE, 32'sd3, INT_MIN);
    send_command(MODE_ENQUEUE, INT_MAX, INT_MAX);
    send_command(MODE_ENQUEUE, INT_MIN, -32'sd1);
    send_command(MODE_ENQUEUE, -32'sd1, INT_MAX);
    repeat (7) send_command(MODE_DEQUEUE, -32'sd1, -32'sd1);
    send_command(MODE_ENQUEUE, 32'sd0, 32'sd1);
    send_command(MODE_ENQUEUE, 32'sd5, INT_MIN);
    send_command(MODE_ENQUEUE, 32'sd6, INT_MIN);
    repeat (4) send_command(MODE_DEQUEUE, 32'sd0, 32'sd0);

    // Fill beyond capacity, pause until all results are in, then drain beyond empty.
    run_phase(DEPTH + 4, 100);
    wait_until_drained();
    run_phase(DEPTH + 4, 0);

    // Random phases leaning towards filling, draining or neither.
    while (items_sent < ITEMS_TARGET) begin
      steady = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 150);
      if (phase_len > ITEMS_TARGET - items_sent) begin
        phase_len = ITEMS_TARGET - items_sent;
      end
      case ($urandom_range(0, 2))
        0: run_phase(phase_len, 85);
        1: run_phase(phase_len, 15);
        default: run_phase(phase_len, 50);
      endcase
      if ($urandom_range(0, 4) == 0) wait_until_drained();
    end
    steady = 1'b0;

    wait_until_drained();
    repeat (5) @(posedge clk);
    if (book.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
